// ----- src/mslst_pkg.sv -----
// Package for the multi-slot lap split timer: shared constants, codes and word types.
// No dependencies; every other file of the block imports it.
package mslst_pkg;

  localparam int SLOTS_DEF     = 8;
  localparam int LOG_DEPTH_DEF = 256;
  localparam int CMDQ_DEPTH    = 2;

  localparam int TIME_W     = 32;
  localparam int LAPS_W     = 16;
  localparam int SLOT_IN_W  = 3;
  localparam int STRENGTH_W = 8;
  localparam int LOG_IDX_W  = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [LAPS_W-1:0] LAP_MAX = '1;

  // input mode codes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_CROSS = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RACE_RUNNING = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAP_MODE     = 8'd1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CROSS = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [SLOT_IN_W-1:0]         slot;
    logic [TIME_W-1:0]            timestamp;
    logic signed [STRENGTH_W-1:0] signal_strength;
  } item_t;

  typedef struct packed {
    logic                         kind;
    logic [SLOT_IN_W-1:0]         out_slot;
    logic [TIME_W-1:0]            lap_ms;
    logic [TIME_W-1:0]            best_ms;
    logic [LAPS_W-1:0]            lap_number;
    logic                         new_best;
    logic signed [STRENGTH_W-1:0] out_strength;
    logic [TIME_W-1:0]            out_time;
    logic                         logged;
    logic [LOG_IDX_W-1:0]         log_index;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    op_t                          op;
    logic [SLOT_IN_W-1:0]         slot;
    logic [TIME_W-1:0]            ts;
    logic signed [STRENGTH_W-1:0] strength;
  } cmd_t;

endpackage

// ----- src/mslst_chan_if.sv -----
// Valid/ready channel interfaces for the lap timer: input, result and config write.
// Depends on mslst_pkg for the word types.
interface mslst_in_if;
  import mslst_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mslst_out_if;
  import mslst_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mslst_cfg_if;
  import mslst_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/mslst_cmd_fifo.sv -----
// Short command queue between the front (classify) and back (execute) of the timer.
// Depends on mslst_pkg (cmd_t, CMDQ_DEPTH).
module mslst_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mslst_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output mslst_pkg::cmd_t rd_cmd,
  output logic          not_empty
);
  import mslst_pkg::*;

  localparam int DEPTH = CMDQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ----- src/mslst_front.sv -----
// Front of the lap timer: holds the config registers, accepts input words and
// classifies them into commands for the queue. Depends on mslst_pkg and the channel interfaces.
module mslst_front #(
  parameter int SLOTS = mslst_pkg::SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  mslst_in_if.sink        in_ch,
  mslst_cfg_if.sink       cfg_ch,
  output mslst_pkg::cmd_t push_cmd,
  output logic            push,
  input  logic            q_full,
  output logic            lap_mode
);
  import mslst_pkg::*;

  logic race_running_r, race_running_nxt;
  logic lap_mode_r, lap_mode_nxt;
  logic keep;
  logic slot_ok;
  op_t  op;

  assign cfg_ch.ready = 1'b1;
  assign lap_mode     = lap_mode_r;

  // register writes; unknown indexes drop
  always_comb begin
    race_running_nxt = race_running_r;
    lap_mode_nxt     = lap_mode_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_RACE_RUNNING: race_running_nxt = cfg_ch.data.value[0];
        REG_LAP_MODE:     lap_mode_nxt     = cfg_ch.data.value[0];
        default: ;
      endcase
    end
  end

  assign slot_ok = (32'(in_ch.data.slot) < 32'(SLOTS));

  // drop crossings outside a race or beyond the slot count, and the unused mode
  always_comb begin
    keep = 1'b0;
    op   = OP_START;
    case (in_ch.data.mode)
      MODE_START: begin
        keep = 1'b1;
        op   = OP_START;
      end
      MODE_CROSS: begin
        keep = race_running_r && slot_ok;
        op   = OP_CROSS;
      end
      MODE_CLEAR: begin
        keep = 1'b1;
        op   = OP_CLEAR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ch.ready       = !q_full;
  assign push              = in_ch.valid && !q_full && keep;
  assign push_cmd.op       = op;
  assign push_cmd.slot     = in_ch.data.slot;
  assign push_cmd.ts       = in_ch.data.timestamp;
  assign push_cmd.strength = in_ch.data.signal_strength;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      race_running_r <= 1'b0;
      lap_mode_r     <= 1'b0;
    end else begin
      race_running_r <= race_running_nxt;
      lap_mode_r     <= lap_mode_nxt;
    end
  end

endmodule

// ----- src/mslst_back.sv -----
// Back of the lap timer: executes queued commands against the per-slot records
// and drives the result register. Depends on mslst_pkg and the channel interfaces.
module mslst_back #(
  parameter int SLOTS     = mslst_pkg::SLOTS_DEF,
  parameter int LOG_DEPTH = mslst_pkg::LOG_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            lap_mode,
  input  logic            q_valid,
  input  mslst_pkg::cmd_t q_cmd,
  output logic            q_pop,
  mslst_out_if.source     out_ch
);
  import mslst_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LOG_W  = $clog2(LOG_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  logic [TIME_W-1:0] last_r  [SLOTS];
  logic [TIME_W-1:0] last_nxt[SLOTS];
  logic [TIME_W-1:0] best_r  [SLOTS];
  logic [TIME_W-1:0] best_nxt[SLOTS];
  logic [LAPS_W-1:0] total_r  [SLOTS];
  logic [LAPS_W-1:0] total_nxt[SLOTS];
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [LOG_W-1:0]  fill_r, fill_nxt;

  // crossing in flight
  cmd_t              cur_r, cur_nxt;
  logic              first_r, first_nxt;
  logic [TIME_W-1:0] lap_r, lap_nxt;
  logic [TIME_W-1:0] best_cur_r, best_cur_nxt;
  logic [LAPS_W-1:0] total_cur_r, total_cur_nxt;

  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  logic [SLOT_W+SLOT_IN_W-1:0] head_ext, cur_ext;
  logic [SLOT_W-1:0]           head_idx, cur_idx;
  logic                        head_first;
  logic [TIME_W-1:0]           head_base;
  logic                        gate;
  logic [LAPS_W-1:0]           total_inc;
  logic                        best_set;
  logic                        log_ok;
  logic [LOG_W+LOG_IDX_W-1:0]  fill_ext;
  logic                        load;

  assign head_ext   = {{SLOT_W{1'b0}}, q_cmd.slot};
  assign head_idx   = head_ext[SLOT_W-1:0];
  assign cur_ext    = {{SLOT_W{1'b0}}, cur_r.slot};
  assign cur_idx    = cur_ext[SLOT_W-1:0];
  assign head_first = (last_r[head_idx] == '0);
  assign head_base  = head_first ? start_r : last_r[head_idx];

  assign gate      = first_r && (lap_r == '0);
  assign total_inc = (total_cur_r == LAP_MAX) ? total_cur_r : total_cur_r + 1'b1;
  assign best_set  = (lap_r != '0) && ((best_cur_r == '0) || (lap_r < best_cur_r));
  assign log_ok    = (fill_r < LOG_W'(LOG_DEPTH));
  assign fill_ext  = {{LOG_IDX_W{1'b0}}, fill_r};
  assign load      = (state_r == ST_CALC) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    best_nxt      = best_r;
    total_nxt     = total_r;
    start_nxt     = start_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    lap_nxt       = lap_r;
    best_cur_nxt  = best_cur_r;
    total_cur_nxt = total_cur_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_pop         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_START: begin
              start_nxt = q_cmd.ts;
              if (lap_mode) begin
                for (int i = 0; i < SLOTS; i++) begin
                  last_nxt[i] = q_cmd.ts;
                end
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < SLOTS; i++) begin
                last_nxt[i]  = '0;
                best_nxt[i]  = '0;
                total_nxt[i] = '0;
              end
              fill_nxt = '0;
            end
            OP_CROSS: begin
              cur_nxt       = q_cmd;
              first_nxt     = head_first;
              lap_nxt       = (head_first && (start_r == '0)) ? '0 : q_cmd.ts - head_base;
              best_cur_nxt  = best_r[head_idx];
              total_cur_nxt = total_r[head_idx];
              state_nxt     = ST_CALC;
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        if (load) begin
          last_nxt[cur_idx]    = cur_r.ts;
          res_nxt.out_slot     = cur_r.slot;
          res_nxt.out_strength = cur_r.strength;
          res_nxt.out_time     = cur_r.ts;
          if (gate) begin
            res_nxt.kind       = 1'b0;
            res_nxt.lap_ms     = '0;
            res_nxt.best_ms    = best_cur_r;
            res_nxt.lap_number = total_cur_r;
            res_nxt.new_best   = 1'b0;
            res_nxt.logged     = 1'b0;
            res_nxt.log_index  = '0;
          end else begin
            total_nxt[cur_idx] = total_inc;
            if (best_set) begin
              best_nxt[cur_idx] = lap_r;
            end
            if (log_ok) begin
              fill_nxt = fill_r + 1'b1;
            end
            res_nxt.kind       = 1'b1;
            res_nxt.lap_ms     = lap_r;
            res_nxt.best_ms    = best_set ? lap_r : best_cur_r;
            res_nxt.lap_number = total_inc;
            res_nxt.new_best   = best_set;
            res_nxt.logged     = log_ok;
            res_nxt.log_index  = log_ok ? fill_ext[LOG_IDX_W-1:0] : '0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        last_r[i]  <= '0;
        best_r[i]  <= '0;
        total_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      best_r      <= best_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    first_r     <= first_nxt;
    lap_r       <= lap_nxt;
    best_cur_r  <= best_cur_nxt;
    total_cur_r <= total_cur_nxt;
    res_r       <= res_nxt;
  end

endmodule

// ----- src/multi_slot_lap_split_timer_top.sv -----
// Top level of the multi-slot lap split timer: front, command queue and back.
// Depends on mslst_pkg, the channel interfaces, mslst_front, mslst_cmd_fifo, mslst_back.
//
// The timer keeps, for each pilot slot, the last gate crossing time, the best lap
// and a saturating lap count, plus the race start time and a lap log fill count.
// Input words carry a mode (race start acknowledge, lap crossing, clear records),
// a slot, a millisecond timestamp and a signal strength. A race start stores the
// start time and, with lap_mode set, seeds every slot's last crossing time with it;
// a clear wipes all slot records and the log fill but keeps the start time; neither
// gives a result. A crossing while race_running is set, for a slot below SLOTS,
// gives exactly one result word: a gate start (kind 0) when it is the slot's first
// crossing and measures no time, otherwise a counted lap (kind 1) with the lap time
// (32-bit wrap), the best lap, the count, a new-best flag and, while fewer than
// LOG_DEPTH laps are logged, the log position. Other input words are taken and
// dropped. Timing: the front takes one input word per cycle whenever the two-deep
// command queue has room, independent of a stalled result. The back executes a start
// or clear in ST_IDLE and a crossing in two states: ST_IDLE (record read and lap
// subtract), then ST_CALC (best compare and write-back). The back takes no new
// command until the crossing's record read-modify-write is done; a result that
// is not taken holds the back in ST_CALC. Records live in flip-flops, so reset clears
// them at once with no clearing pass. Config writes are taken every cycle
// (cfg_ch.ready is always high) and must happen only while the block is idle.
module multi_slot_lap_split_timer_top #(
  parameter int SLOTS     = mslst_pkg::SLOTS_DEF,
  parameter int LOG_DEPTH = mslst_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mslst_in_if.sink    in_ch,
  mslst_out_if.source out_ch,
  mslst_cfg_if.sink   cfg_ch
);
  import mslst_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic lap_mode;

  // classify input words and hold config
  mslst_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .push_cmd (push_cmd),
    .push     (push),
    .q_full   (q_full),
    .lap_mode (lap_mode)
  );

  // decouple front from back
  mslst_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .rd_cmd    (head_cmd),
    .not_empty (q_valid)
  );

  // update slot records and emit results
  mslst_back #(
    .SLOTS     (SLOTS),
    .LOG_DEPTH (LOG_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .lap_mode (lap_mode),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

// ----- src/mslst_checker.sv -----
// Port-level checks on the lap timer's result channel, bound to the top level.
// Depends on mslst_pkg for the result word type.
module mslst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input mslst_pkg::result_t out_res
);
  import mslst_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_res))
    else $error("result word changed while stalled");

  a_gate_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.kind |-> out_res.lap_ms == '0 && !out_res.new_best &&
                                   !out_res.logged && out_res.log_index == '0)
    else $error("gate start carries lap fields");

  a_new_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.new_best |-> out_res.kind && out_res.lap_ms != '0 &&
                                      out_res.best_ms == out_res.lap_ms)
    else $error("new best does not match lap time");

  a_log_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.logged |-> out_res.log_index == '0)
    else $error("log index set on an unlogged lap");

endmodule

bind multi_slot_lap_split_timer_top mslst_checker u_mslst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_res   (out_ch.data)
);
